// File: rtl/core/crc16mh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16mh_pkg
// Shared widths, register indexes, command/status types and the byte-wise
// CRC-16/MODBUS update for the key hash block.
// ----------------------------------------------------------------------------
package crc16mh_pkg;

  localparam int unsigned KEY_W      = 8;
  localparam int unsigned CRC_W      = 16;
  localparam int unsigned BASE_W     = 16;
  localparam int unsigned LIMIT_W    = 32;
  localparam int unsigned HASH_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT = CFG_IDX_W'(1);

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;  // reflected 0x8005

  // restoring divider: one dividend bit per step
  localparam int unsigned DIV_STEPS = CRC_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic crc_upd;   // fold byte into running CRC
    logic crc_clr;   // last byte: CRC back to init
    logic div_load;  // capture swapped CRC, divisor and flags
    logic div_step;  // one restoring-division step
    logic out_load;  // load result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic lim_zero;  // hash_limit == 0
    logic div_zero;  // limit + base - 1 == 0 (mod 2^32)
  } dp_sts_t;

  // one byte, LSB first, eight shift/fold steps on 16 bits
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [KEY_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-KEY_W){1'b0}}, b};
    for (int k = 0; k < KEY_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/core/crc16mh_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16mh channel interfaces
// Valid/ready channels for key bytes, hash results and register writes.
// ----------------------------------------------------------------------------
interface crc16mh_in_if;
  logic                            valid;
  logic                            ready;
  logic [crc16mh_pkg::KEY_W-1:0]   key_byte;
  logic                            last_byte;

  modport source (output valid, key_byte, last_byte, input ready);
  modport sink   (input valid, key_byte, last_byte, output ready);
endinterface

interface crc16mh_out_if;
  logic                            valid;
  logic                            ready;
  logic [crc16mh_pkg::HASH_W-1:0]  hash_value;
  logic                            divide_error;

  modport source (output valid, hash_value, divide_error, input ready);
  modport sink   (input valid, hash_value, divide_error, output ready);
endinterface

interface crc16mh_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [crc16mh_pkg::CFG_IDX_W-1:0]    idx;
  logic [crc16mh_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// File: rtl/core/crc16mh_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16mh_dp
// Datapath: config registers, CRC register, restoring divider and result
// register.
// ----------------------------------------------------------------------------
module crc16mh_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr,
  input  logic [crc16mh_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [crc16mh_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [crc16mh_pkg::KEY_W-1:0]       in_key,
  input  crc16mh_pkg::ctrl_cmd_t              cmd,
  output crc16mh_pkg::dp_sts_t                sts,
  output logic [crc16mh_pkg::HASH_W-1:0]      hash_value,
  output logic                                divide_error
);

  localparam int unsigned CW = crc16mh_pkg::CRC_W;
  localparam int unsigned LW = crc16mh_pkg::LIMIT_W;
  localparam int unsigned RW = CW + 1;  // remainder plus shifted-in bit

  logic [crc16mh_pkg::BASE_W-1:0]  base_r;
  logic [LW-1:0]                   limit_r;
  logic [CW-1:0]                   crc_r;
  logic [CW-1:0]                   dvd_r;
  logic [RW-1:0]                   rem_r;
  logic [LW-1:0]                   dsr_r;
  logic                            lz_r;
  logic                            err_r;
  logic [crc16mh_pkg::HASH_W-1:0]  hash_r;
  logic                            derr_r;

  logic [CW-1:0] crc_new;
  logic [CW-1:0] swapped;
  logic [LW-1:0] divisor;
  logic [RW-1:0] rem_sh;
  logic          rem_ge;

  assign crc_new = crc16mh_pkg::crc_byte(crc_r, in_key);
  assign swapped = {crc_new[7:0], crc_new[CW-1:8]};
  assign divisor = limit_r + {{(LW-crc16mh_pkg::BASE_W){1'b0}}, base_r} - LW'(1);

  assign sts.lim_zero = (limit_r == '0);
  assign sts.div_zero = (divisor == '0);

  assign rem_sh = {rem_r[CW-1:0], dvd_r[CW-1]};
  assign rem_ge = ({{(LW-RW){1'b0}}, rem_sh} >= dsr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      limit_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_idx == crc16mh_pkg::CFG_IDX_BASE) begin
        base_r <= cfg_data[crc16mh_pkg::BASE_W-1:0];
      end else if (cfg_idx == crc16mh_pkg::CFG_IDX_LIMIT) begin
        limit_r <= cfg_data[LW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= crc16mh_pkg::CRC_INIT;
    end else if (cmd.crc_clr) begin
      crc_r <= crc16mh_pkg::CRC_INIT;
    end else if (cmd.crc_upd) begin
      crc_r <= crc_new;
    end
  end

  // divider and result payload: no reset needed
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd_r <= swapped;
      rem_r <= '0;
      dsr_r <= divisor;
      lz_r  <= sts.lim_zero;
      err_r <= !sts.lim_zero && sts.div_zero;
    end else if (cmd.div_step) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_ge ? (rem_sh - dsr_r[RW-1:0]) : rem_sh;
    end
    if (cmd.out_load) begin
      hash_r <= lz_r ? base_r : (err_r ? '0 : rem_r[CW-1:0]);
      derr_r <= err_r;
    end
  end

  assign hash_value   = hash_r;
  assign divide_error = derr_r;

endmodule

// File: rtl/core/crc16mh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16mh_ctrl
// Controller: accepts key bytes, sequences the divider, owns output valid.
// ----------------------------------------------------------------------------
module crc16mh_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_last,
  output logic                    in_ready,
  input  logic                    out_ready,
  output logic                    out_valid,
  input  crc16mh_pkg::dp_sts_t    sts,
  output crc16mh_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam int unsigned CW = crc16mh_pkg::CNT_W;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          in_acc;
  logic          out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_last) begin
            cmd.crc_clr  = 1'b1;
            cmd.div_load = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = (sts.lim_zero || sts.div_zero) ? ST_DONE : ST_DIV;
          end else begin
            cmd.crc_upd = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CW'(crc16mh_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/crc16_modbus_hash_modulo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_modbus_hash_modulo
// CRC-16/MODBUS over a key, one byte per beat, byte-swapped at the last byte
// and reduced modulo (hash_limit + hash_base - 1), or hash_base if the limit
// is zero; a zero divisor gives hash 0 with divide_error set.
// ----------------------------------------------------------------------------
//
//  channel   dir   payload                          beat means
//  in_bus    in    key_byte[7:0], last_byte         one key byte
//  out_bus   out   hash_value[15:0], divide_error   one hash per key
//  cfg_bus   in    idx[1:0], data[31:0]             one register write
//
//  Timing:
//  - A key byte that is not last is folded into the CRC register when it is
//    accepted; the CRC update is a single combinational byte step.
//  - A last byte loads the divider, then runs 16 restoring steps when a division
//    is needed, one bit of the swapped CRC per cycle, and then loads the result;
//    the steps are skipped when the limit is zero or the divisor is zero.
//  - in_bus.ready is low while the divider runs and while a finished result
//    waits for a full output register; bytes keep flowing while an older
//    result sits on out_bus.
//  - Reset (rst_n low, synchronous) clears both config registers and sets the
//    CRC to 0xFFFF. cfg_bus.ready is always high.
//
module crc16_modbus_hash_modulo (
  input  logic                  clk,
  input  logic                  rst_n,
  crc16mh_in_if.sink            in_bus,
  crc16mh_out_if.source         out_bus,
  crc16mh_cfg_if.sink           cfg_bus
);

  crc16mh_pkg::ctrl_cmd_t cmd;
  crc16mh_pkg::dp_sts_t   sts;

  // register writes land in the config registers, never stalled
  assign cfg_bus.ready = 1'b1;

  crc16mh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_last   (in_bus.last_byte),
    .in_ready  (in_bus.ready),
    .out_ready (out_bus.ready),
    .out_valid (out_bus.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  crc16mh_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr       (cfg_bus.valid),
    .cfg_idx      (cfg_bus.idx),
    .cfg_data     (cfg_bus.data),
    .in_key       (in_bus.key_byte),
    .cmd          (cmd),
    .sts          (sts),
    .hash_value   (out_bus.hash_value),
    .divide_error (out_bus.divide_error)
  );

endmodule

// File: rtl/core/crc16mh_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16mh_chk
// Port-level checks on the key hash block, bound to the top level.
// ----------------------------------------------------------------------------
module crc16mh_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_last,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [crc16mh_pkg::HASH_W-1:0]     hash_value,
  input logic                               divide_error
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // error results carry a zero hash
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && divide_error |-> hash_value == '0)
    else $error("divide error with nonzero hash");

  // the last byte of a key always closes the input for the reduction
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input open right after last byte");

  // a new result is only launched from the done state, with input closed
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a finished key");

endmodule

bind crc16_modbus_hash_modulo crc16mh_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_bus.valid),
  .in_ready     (in_bus.ready),
  .in_last      (in_bus.last_byte),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .hash_value   (out_bus.hash_value),
  .divide_error (out_bus.divide_error)
);
